// File: rtl/core/adr_pkg.sv
// ----------------------------------------------------------------------------
// adr_pkg: shared types and constants for the accelerating duty ramp
// Register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package adr_pkg;

  localparam int DUTY_W  = 7;
  localparam int DIV_W   = 8;
  localparam int CFG_W   = 8;
  localparam int INDEX_W = 2;

  // Register indexes on the configuration port
  localparam logic [INDEX_W-1:0] REG_MIN_DUTY      = 2'd0;
  localparam logic [INDEX_W-1:0] REG_MAX_DUTY      = 2'd1;
  localparam logic [INDEX_W-1:0] REG_START_DIVIDER = 2'd2;
  localparam logic [INDEX_W-1:0] REG_ACCEL_STEP    = 2'd3;

  // Reset values
  localparam logic [DUTY_W-1:0] MIN_DUTY_RESET      = 7'd40;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RESET      = 7'd95;
  localparam logic [DIV_W-1:0]  START_DIVIDER_RESET = 8'd25;
  localparam logic [DIV_W-1:0]  ACCEL_STEP_RESET    = 8'd2;
  localparam logic [DUTY_W-1:0] DUTY_RESET          = 7'd40;

  typedef struct packed {
    logic [DUTY_W-1:0] min_duty;
    logic [DUTY_W-1:0] max_duty;
    logic [DIV_W-1:0]  start_divider;
    logic [DIV_W-1:0]  accel_step;
  } cfg_t;

endpackage

// File: rtl/core/adr_cfg.sv
// ----------------------------------------------------------------------------
// adr_cfg: configuration registers
// Holds the duty limits, start divider and acceleration step.
// ----------------------------------------------------------------------------
module adr_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [adr_pkg::INDEX_W-1:0]        cfg_index,
  input  logic [adr_pkg::CFG_W-1:0]          cfg_data,
  output adr_pkg::cfg_t                      cfg
);

  // Register file write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_duty      <= adr_pkg::MIN_DUTY_RESET;
      cfg.max_duty      <= adr_pkg::MAX_DUTY_RESET;
      cfg.start_divider <= adr_pkg::START_DIVIDER_RESET;
      cfg.accel_step    <= adr_pkg::ACCEL_STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        adr_pkg::REG_MIN_DUTY:      cfg.min_duty      <= cfg_data[adr_pkg::DUTY_W-1:0];
        adr_pkg::REG_MAX_DUTY:      cfg.max_duty      <= cfg_data[adr_pkg::DUTY_W-1:0];
        adr_pkg::REG_START_DIVIDER: cfg.start_divider <= cfg_data[adr_pkg::DIV_W-1:0];
        adr_pkg::REG_ACCEL_STEP:    cfg.accel_step    <= cfg_data[adr_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/adr_step.sv
// ----------------------------------------------------------------------------
// adr_step: next-state logic for one tick
// Direction reload, step and acceleration counters, saturating duty update.
// ----------------------------------------------------------------------------
module adr_step #(
  parameter int COUNT_BITS = 8
) (
  input  adr_pkg::cfg_t                    cfg,
  input  logic                             up,
  input  logic                             ramping_up,
  input  logic [adr_pkg::DIV_W-1:0]        ticks_per_change,
  input  logic [COUNT_BITS-1:0]            tick_count,
  input  logic [COUNT_BITS-1:0]            accel_count,
  input  logic [adr_pkg::DUTY_W-1:0]       duty,
  output logic [adr_pkg::DIV_W-1:0]        ticks_per_change_next,
  output logic [COUNT_BITS-1:0]            tick_count_next,
  output logic [COUNT_BITS-1:0]            accel_count_next,
  output logic [adr_pkg::DUTY_W-1:0]       duty_next,
  output logic                             changed
);

  localparam int CMP_W = (COUNT_BITS > adr_pkg::DIV_W) ? COUNT_BITS : adr_pkg::DIV_W;

  logic                        dir_change;
  logic [adr_pkg::DIV_W-1:0]   tpc0;
  logic [COUNT_BITS-1:0]       tc1;
  logic [COUNT_BITS-1:0]       ac1;
  logic                        do_step;
  logic                        do_accel;

  // Direction change reloads the divider and clears both counters
  assign dir_change = (up != ramping_up);
  assign tpc0       = dir_change ? cfg.start_divider : ticks_per_change;
  assign tc1        = (dir_change ? '0 : tick_count) + COUNT_BITS'(1);
  assign ac1        = (dir_change ? '0 : accel_count) + COUNT_BITS'(1);

  // Threshold compares at a common width
  assign do_step  = CMP_W'(tc1) >= CMP_W'(tpc0);
  assign do_accel = CMP_W'(ac1) >= CMP_W'(cfg.accel_step);

  // Saturating duty step, each direction tests only its own limit
  always_comb begin
    duty_next = duty;
    if (do_step) begin
      if (up) begin
        if (duty < cfg.max_duty) duty_next = duty + adr_pkg::DUTY_W'(1);
      end else begin
        if (duty > cfg.min_duty) duty_next = duty - adr_pkg::DUTY_W'(1);
      end
    end
  end

  assign tick_count_next  = do_step  ? '0 : tc1;
  assign accel_count_next = do_accel ? '0 : ac1;

  // Divider shrinks toward 1
  assign ticks_per_change_next = (do_accel && (tpc0 > adr_pkg::DIV_W'(1)))
                                 ? tpc0 - adr_pkg::DIV_W'(1) : tpc0;

  assign changed = (duty_next != duty);

endmodule

// File: rtl/core/accelerating_duty_ramp.sv
// ----------------------------------------------------------------------------
// accelerating_duty_ramp: duty ramp with accelerating step rate
// Input register, one tick of ramp logic, result register.
// ----------------------------------------------------------------------------
// One tick word is taken every clock while the output is not stalled; the
// tick passes the input register, then the result register, where the
// result word becomes valid. The rate is set only by out_stall, as the
// ramp update between the two registers is combinational. Configuration
// takes effect on the next tick processed; a new start_divider is loaded
// at the next direction change.
module accelerating_duty_ramp #(
  parameter int COUNT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [adr_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [adr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          button_held,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [adr_pkg::DUTY_W-1:0]    duty_percent,
  output logic                          duty_changed
);

  adr_pkg::cfg_t cfg;

  // Input register
  logic s1_valid;
  logic s1_button;
  logic s1_adv;
  logic out_free;

  // Ramp state
  logic                        ramping_up;
  logic [adr_pkg::DIV_W-1:0]   ticks_per_change;
  logic [COUNT_BITS-1:0]       tick_count;
  logic [COUNT_BITS-1:0]       accel_count;
  logic [adr_pkg::DUTY_W-1:0]  duty;

  logic [adr_pkg::DIV_W-1:0]   ticks_per_change_next;
  logic [COUNT_BITS-1:0]       tick_count_next;
  logic [COUNT_BITS-1:0]       accel_count_next;
  logic [adr_pkg::DUTY_W-1:0]  duty_next;
  logic                        changed;

  adr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  adr_step #(.COUNT_BITS(COUNT_BITS)) u_step (
    .cfg                   (cfg),
    .up                    (s1_button),
    .ramping_up            (ramping_up),
    .ticks_per_change      (ticks_per_change),
    .tick_count            (tick_count),
    .accel_count           (accel_count),
    .duty                  (duty),
    .ticks_per_change_next (ticks_per_change_next),
    .tick_count_next       (tick_count_next),
    .accel_count_next      (accel_count_next),
    .duty_next             (duty_next),
    .changed               (changed)
  );

  // Handshake: result register frees when empty or taken
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_button <= button_held;
    end
  end

  // Ramp state update, one tick per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      ramping_up       <= 1'b1;
      ticks_per_change <= adr_pkg::START_DIVIDER_RESET;
      tick_count       <= '0;
      accel_count      <= '0;
      duty             <= adr_pkg::DUTY_RESET;
    end else if (s1_adv) begin
      ramping_up       <= s1_button;
      ticks_per_change <= ticks_per_change_next;
      tick_count       <= tick_count_next;
      accel_count      <= accel_count_next;
      duty             <= duty_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      duty_percent <= duty_next;
      duty_changed <= changed;
    end
  end

`ifndef ASSERT_OFF
  // A held result always matches the stored duty
  a_out_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_percent == duty))
    else $error("result duty differs from ramp state");

  // Input stalls only behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // Direction register follows the processed tick
  a_direction: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (ramping_up == $past(s1_button)))
    else $error("direction not taken from processed tick");

  // Changed flag agrees with a real duty move
  a_changed: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (duty_changed == (duty != $past(duty))))
    else $error("changed flag disagrees with duty update");
`endif

endmodule
